// ----- hw/rtl/sdf_pkg.sv -----
package sdf_pkg;

    localparam int IDX_WIDTH      = 9;
    localparam int IN_WIDTH       = 16;
    localparam int OUT_WIDTH      = 48;
    localparam int TAPCNT_WIDTH   = 9;
    localparam int DECIM_WIDTH    = 3;
    localparam int PKTLEN_WIDTH   = 16;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEFF  = 1'b1;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TAP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DECIMATION    = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PACKET_LENGTH = 2'd2;

    localparam logic [TAPCNT_WIDTH-1:0] TAPCNT_RESET = 9'd127;
    localparam logic [DECIM_WIDTH-1:0]  DECIM_RESET  = 3'd1;
    localparam logic [PKTLEN_WIDTH-1:0] PKTLEN_RESET = 16'd256;

    typedef struct packed {
        logic [TAPCNT_WIDTH-1:0] tap_count_m1;
        logic [DECIM_WIDTH-1:0]  decimation;
        logic [PKTLEN_WIDTH-1:0] packet_length;
    } sdf_cfg_t;

    typedef struct packed {
        logic mem_clear;
        logic coeff_wr;
        logic sample_wr;
        logic tap_rd;
        logic tap_first;
        logic load_left;
        logic load_right;
    } sdf_cmd_t;

    typedef struct packed {
        logic mac_busy;
        logic out_free;
    } sdf_status_t;

endpackage

// ----- hw/rtl/stereo_decimating_fir_filter_core.sv -----
// Stereo decimating FIR filter.
// Input channel (in_valid/in_ready): opcode 0 carries a left/right sample
// pair, opcode 1 writes coeff_value into the coefficient store at
// coeff_index (indexes at or beyond MAX_TAPS are dropped).
// Every Nth pair (N = decimation, 0 and 1 mean every pair) gives two
// results on the output channel (out_valid/out_ready): the left sum, then
// the right sum, each with packet_end marking the last word of a packet.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 tap_count_m1,
// 1 decimation, 2 packet_length; other indexes are ignored.
// Sequencing: a coefficient write or a pair that gives no output leaves
// the block idle and ready for the next request. An output pair runs one
// shared MAC step per tap for both channels through the read, multiply
// and accumulate registers, then loads the left and right results; ready
// returns with the right result still in the output register.
// Reset: the delay lines and coefficient store are zeroed by a sweep over
// all MAX_TAPS addresses during which in_ready stays low.
// A stalled receiver holds the block in its result-load state; no result
// is dropped.
module stereo_decimating_fir_filter_core
    import sdf_pkg::*;
#(
    parameter int MAX_TAPS     = 512,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEFF_WIDTH  = 16,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [IDX_WIDTH-1:0]        coeff_index,
    input  logic signed [IN_WIDTH-1:0]  coeff_value,
    input  logic signed [IN_WIDTH-1:0]  left_sample,
    input  logic signed [IN_WIDTH-1:0]  right_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [OUT_WIDTH-1:0] filtered,
    output logic                        packet_end
);

    localparam int AW = $clog2(MAX_TAPS);

    sdf_cfg_t    cfg_reg, cfg_next;
    sdf_cmd_t    cmd;
    sdf_status_t status;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] coeff_rd_addr;
    logic [AW-1:0] delay_rd_addr;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TAP_COUNT:     cfg_next.tap_count_m1  = TAPCNT_WIDTH'(cfg_data);
                CFG_DECIMATION:    cfg_next.decimation    = DECIM_WIDTH'(cfg_data);
                CFG_PACKET_LENGTH: cfg_next.packet_length = PKTLEN_WIDTH'(cfg_data);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_count_m1  <= TAPCNT_RESET;
            cfg_reg.decimation    <= DECIM_RESET;
            cfg_reg.packet_length <= PKTLEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdf_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .coeff_index   (coeff_index),
        .cfg           (cfg_reg),
        .status        (status),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .coeff_rd_addr (coeff_rd_addr),
        .delay_rd_addr (delay_rd_addr)
    );

    sdf_datapath #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEFF_WIDTH  (COEFF_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .coeff_rd_addr (coeff_rd_addr),
        .delay_rd_addr (delay_rd_addr),
        .coeff_value   (coeff_value),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .packet_length (cfg_reg.packet_length),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .filtered      (filtered),
        .packet_end    (packet_end)
    );

endmodule

// ----- hw/rtl/sdf_ctrl.sv -----
module sdf_ctrl
    import sdf_pkg::*;
#(
    parameter int MAX_TAPS = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [IDX_WIDTH-1:0]          coeff_index,
    input  sdf_cfg_t                      cfg,
    input  sdf_status_t                   status,
    output sdf_cmd_t                      cmd,
    output logic [$clog2(MAX_TAPS)-1:0]   wr_addr,
    output logic [$clog2(MAX_TAPS)-1:0]   coeff_rd_addr,
    output logic [$clog2(MAX_TAPS)-1:0]   delay_rd_addr
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MAC    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_EMIT_L = 3'd4;
    localparam logic [2:0] ST_EMIT_R = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [AW-1:0]          tap_reg, tap_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic [DECIM_WIDTH-1:0] decim_reg, decim_next;

    logic                   accept;
    logic                   coeff_ok;
    logic [DECIM_WIDTH-1:0] decim_inc;
    logic                   fire;
    logic [AW-1:0]          last_tap;
    logic [AW-1:0]          wp_inc;
    logic [AW-1:0]          rd_dec;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign coeff_ok  = 32'(coeff_index) < MAX_TAPS;
    assign decim_inc = decim_reg + 1'b1;
    assign fire      = decim_inc >= cfg.decimation;
    assign last_tap  = (32'(cfg.tap_count_m1) >= MAX_TAPS) ? LAST_ADDR
                                                            : AW'(cfg.tap_count_m1);
    assign wp_inc    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
    assign rd_dec    = (rd_addr_reg == '0) ? LAST_ADDR : rd_addr_reg - 1'b1;

    assign coeff_rd_addr = tap_reg;
    assign delay_rd_addr = rd_addr_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        wp_next       = wp_reg;
        tap_next      = tap_reg;
        rd_addr_next  = rd_addr_reg;
        decim_next    = decim_reg;
        cmd           = '0;
        wr_addr       = wp_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.mem_clear = 1'b1;
                wr_addr       = clr_addr_reg;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_COEFF)
                    begin
                        cmd.coeff_wr = coeff_ok;
                        wr_addr      = AW'(coeff_index);
                    end
                    else
                    begin
                        cmd.sample_wr = 1'b1;
                        if (fire)
                        begin
                            decim_next   = '0;
                            tap_next     = '0;
                            rd_addr_next = wp_reg;
                            state_next   = ST_MAC;
                        end
                        else
                        begin
                            decim_next = decim_inc;
                            wp_next    = wp_inc;
                        end
                    end
                end
            end
            ST_MAC:
            begin
                cmd.tap_rd    = 1'b1;
                cmd.tap_first = (tap_reg == '0);
                if (tap_reg == last_tap)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next     = tap_reg + 1'b1;
                    rd_addr_next = rd_dec;
                end
            end
            ST_DRAIN:
            begin
                if (!status.mac_busy)
                begin
                    state_next = ST_EMIT_L;
                end
            end
            ST_EMIT_L:
            begin
                if (status.out_free)
                begin
                    cmd.load_left = 1'b1;
                    state_next    = ST_EMIT_R;
                end
            end
            ST_EMIT_R:
            begin
                if (status.out_free)
                begin
                    cmd.load_right = 1'b1;
                    wp_next        = wp_inc;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            wp_reg       <= '0;
            tap_reg      <= '0;
            rd_addr_reg  <= '0;
            decim_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            wp_reg       <= wp_next;
            tap_reg      <= tap_next;
            rd_addr_reg  <= rd_addr_next;
            decim_reg    <= decim_next;
        end
    end

endmodule

// ----- hw/rtl/sdf_datapath.sv -----
module sdf_datapath
    import sdf_pkg::*;
#(
    parameter int MAX_TAPS     = 512,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEFF_WIDTH  = 16,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdf_cmd_t                      cmd,
    input  logic [$clog2(MAX_TAPS)-1:0]   wr_addr,
    input  logic [$clog2(MAX_TAPS)-1:0]   coeff_rd_addr,
    input  logic [$clog2(MAX_TAPS)-1:0]   delay_rd_addr,
    input  logic signed [IN_WIDTH-1:0]    coeff_value,
    input  logic signed [IN_WIDTH-1:0]    left_sample,
    input  logic signed [IN_WIDTH-1:0]    right_sample,
    input  logic [PKTLEN_WIDTH-1:0]       packet_length,
    output sdf_status_t                   status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_WIDTH-1:0]   filtered,
    output logic                          packet_end
);

    localparam int PW = SAMPLE_WIDTH + COEFF_WIDTH;

    logic [COEFF_WIDTH-1:0]  coeff_mem [MAX_TAPS];
    logic [SAMPLE_WIDTH-1:0] left_mem  [MAX_TAPS];
    logic [SAMPLE_WIDTH-1:0] right_mem [MAX_TAPS];

    logic [COEFF_WIDTH-1:0]  coeff_wr_data;
    logic [SAMPLE_WIDTH-1:0] left_wr_data;
    logic [SAMPLE_WIDTH-1:0] right_wr_data;

    logic signed [COEFF_WIDTH-1:0]  coeff_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] left_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_rd_reg;
    logic                           rd_valid_reg;
    logic                           rd_first_reg;

    logic signed [PW-1:0] prod_l_reg;
    logic signed [PW-1:0] prod_r_reg;
    logic                 prod_valid_reg;
    logic                 prod_first_reg;

    logic [ACC_WIDTH-1:0] acc_l_reg;
    logic [ACC_WIDTH-1:0] acc_r_reg;
    logic [ACC_WIDTH-1:0] prod_l_ext;
    logic [ACC_WIDTH-1:0] prod_r_ext;

    logic [PKTLEN_WIDTH-1:0] out_count_reg, out_count_next;
    logic [PKTLEN_WIDTH-1:0] count_inc;
    logic                    count_last;
    logic                    load;
    logic                    out_valid_reg;
    logic [OUT_WIDTH-1:0]    filtered_reg;
    logic                    packet_end_reg;

    assign coeff_wr_data = COEFF_WIDTH'($unsigned(coeff_value));
    assign left_wr_data  = SAMPLE_WIDTH'($unsigned(left_sample));
    assign right_wr_data = SAMPLE_WIDTH'($unsigned(right_sample));

    always_ff @(posedge clk)
    begin
        if (cmd.mem_clear || cmd.coeff_wr)
        begin
            coeff_mem[wr_addr] <= cmd.mem_clear ? '0 : coeff_wr_data;
        end
        if (cmd.tap_rd)
        begin
            coeff_rd_reg <= coeff_mem[coeff_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_clear || cmd.sample_wr)
        begin
            left_mem[wr_addr]  <= cmd.mem_clear ? '0 : left_wr_data;
            right_mem[wr_addr] <= cmd.mem_clear ? '0 : right_wr_data;
        end
        if (cmd.tap_rd)
        begin
            left_rd_reg  <= left_mem[delay_rd_addr];
            right_rd_reg <= right_mem[delay_rd_addr];
        end
    end

    // read -> multiply -> accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            rd_first_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_first_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= cmd.tap_rd;
            rd_first_reg   <= cmd.tap_first;
            prod_valid_reg <= rd_valid_reg;
            prod_first_reg <= rd_first_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            prod_l_reg <= PW'(left_rd_reg) * PW'(coeff_rd_reg);
            prod_r_reg <= PW'(right_rd_reg) * PW'(coeff_rd_reg);
        end
    end

    assign prod_l_ext = ACC_WIDTH'(prod_l_reg);
    assign prod_r_ext = ACC_WIDTH'(prod_r_reg);

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg)
        begin
            acc_l_reg <= (prod_first_reg ? '0 : acc_l_reg) + prod_l_ext;
            acc_r_reg <= (prod_first_reg ? '0 : acc_r_reg) + prod_r_ext;
        end
    end

    assign load           = cmd.load_left || cmd.load_right;
    assign count_inc      = out_count_reg + 1'b1;
    assign count_last     = (count_inc == packet_length);
    assign out_count_next = count_last ? '0 : count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_count_reg <= out_count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            filtered_reg   <= cmd.load_left ? OUT_WIDTH'(acc_l_reg) : OUT_WIDTH'(acc_r_reg);
            packet_end_reg <= count_last;
        end
    end

    assign status.mac_busy = rd_valid_reg || prod_valid_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign filtered   = $signed(filtered_reg);
    assign packet_end = packet_end_reg;

`ifndef SYNTHESIS
    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(rd_valid_reg || prod_valid_reg))
        else $error("result loaded while taps still in flight");

    a_no_write_during_mac: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tap_rd |-> !(cmd.sample_wr || cmd.coeff_wr || cmd.mem_clear))
        else $error("memory write during tap reads");
`endif

endmodule

// ----- tb/sv/stereo_decimating_fir_filter_core_tb.sv -----
module stereo_decimating_fir_filter_core_tb;
    import sdf_pkg::*;

    localparam int MAX_TAPS      = 512;
    localparam int PERIOD        = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = MAX_TAPS + 32;
    localparam int MAX_REPORTS   = 40;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic                       op;
        logic [IDX_WIDTH-1:0]       cidx;
        logic signed [IN_WIDTH-1:0] cval;
        logic signed [IN_WIDTH-1:0] left;
        logic signed [IN_WIDTH-1:0] right;
    } fir_req_t;

    typedef struct {
        logic [OUT_WIDTH-1:0] sum;
        logic                 last;
    } fir_word_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]    cfg_index    = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data     = '0;
    logic                        in_valid     = 1'b0;
    logic                        in_ready;
    logic                        opcode       = OP_SAMPLE;
    logic [IDX_WIDTH-1:0]        coeff_index  = '0;
    logic signed [IN_WIDTH-1:0]  coeff_value  = '0;
    logic signed [IN_WIDTH-1:0]  left_sample  = '0;
    logic signed [IN_WIDTH-1:0]  right_sample = '0;
    logic                        out_valid;
    logic                        out_ready    = 1'b0;
    logic signed [OUT_WIDTH-1:0] filtered;
    logic                        packet_end;

    stereo_decimating_fir_filter_core #(
        .MAX_TAPS(MAX_TAPS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .left_sample (left_sample),
        .right_sample(right_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .filtered    (filtered),
        .packet_end  (packet_end)
    );

    // shadow copy of the filter state and registers
    logic signed [IN_WIDTH-1:0] left_line  [MAX_TAPS] = '{default: '0};
    logic signed [IN_WIDTH-1:0] right_line [MAX_TAPS] = '{default: '0};
    logic signed [IN_WIDTH-1:0] coeff_mem  [MAX_TAPS] = '{default: '0};
    logic [IDX_WIDTH-1:0]       wr_ptr    = '0;
    logic [DECIM_WIDTH-1:0]     decim_cnt = '0;
    logic [PKTLEN_WIDTH-1:0]    word_cnt  = '0;
    sdf_cfg_t shadow_cfg = '{TAPCNT_RESET, DECIM_RESET, PKTLEN_RESET};

    fir_word_t pending_words[$];
    fir_word_t head_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int words_checked = 0;
    int requests_sent = 0;
    int coeff_writes  = 0;
    int settings_used = 0;

    initial begin
        forever #(PERIOD / 2) clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("Timeout, %0d result words outstanding", pending_words.size());
        $display("Test completed with failures");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic take_packet_end();
        word_cnt = word_cnt + 1'b1;
        if (word_cnt == shadow_cfg.packet_length) begin
            word_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_filter_request(input fir_req_t r);
        int                   taps;
        logic [IDX_WIDTH-1:0] rd;
        logic [OUT_WIDTH-1:0] sum_l;
        logic [OUT_WIDTH-1:0] sum_r;
        longint               prod;
        fir_word_t            w;
        if (r.op == OP_COEFF) begin
            coeff_mem[r.cidx] = r.cval;
        end
        else begin
            left_line[wr_ptr]  = r.left;
            right_line[wr_ptr] = r.right;
            decim_cnt = decim_cnt + 1'b1;
            if (decim_cnt >= shadow_cfg.decimation) begin
                decim_cnt = '0;
                taps = int'(shadow_cfg.tap_count_m1) + 1;
                if (taps > MAX_TAPS)
                    taps = MAX_TAPS;
                sum_l = '0;
                sum_r = '0;
                for (int i = 0; i < taps; i++) begin
                    rd    = wr_ptr - IDX_WIDTH'(i);
                    prod  = longint'(left_line[rd]) * longint'(coeff_mem[i]);
                    sum_l = sum_l + prod[OUT_WIDTH-1:0];
                    prod  = longint'(right_line[rd]) * longint'(coeff_mem[i]);
                    sum_r = sum_r + prod[OUT_WIDTH-1:0];
                end
                w.sum  = sum_l;
                w.last = take_packet_end();
                pending_words.push_back(w);
                w.sum  = sum_r;
                w.last = take_packet_end();
                pending_words.push_back(w);
            end
            wr_ptr = wr_ptr + 1'b1;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_words.size() == 0) begin
                flag_error($sformatf("unexpected result word %h", filtered));
            end
            else begin
                head_word = pending_words.pop_front();
                words_checked++;
                if (filtered !== head_word.sum)
                    flag_error($sformatf("word %0d filtered %h, expected %h",
                                         words_checked, filtered, head_word.sum));
                if (packet_end !== head_word.last)
                    flag_error($sformatf("word %0d packet_end %b, expected %b",
                                         words_checked, packet_end, head_word.last));
            end
        end
    end

    task automatic send_request(input fir_req_t r);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= r.op;
        coeff_index  <= r.cidx;
        coeff_value  <= r.cval;
        left_sample  <= r.left;
        right_sample <= r.right;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_filter_request(r);
        requests_sent++;
        if (r.op == OP_COEFF)
            coeff_writes++;
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle_idle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_WIDTH-1:0]  idx,
                                  input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_TAP_COUNT:     shadow_cfg.tap_count_m1  = data[TAPCNT_WIDTH-1:0];
            CFG_DECIMATION:    shadow_cfg.decimation    = data[DECIM_WIDTH-1:0];
            CFG_PACKET_LENGTH: shadow_cfg.packet_length = data[PKTLEN_WIDTH-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // unused upper data bits are filled with noise
    task automatic configure(input logic [TAPCNT_WIDTH-1:0] taps_m1,
                             input logic [DECIM_WIDTH-1:0]  decim,
                             input logic [PKTLEN_WIDTH-1:0] pkt_len);
        logic [CFG_DATA_WIDTH-1:0] data;
        settle_idle();
        data = CFG_DATA_WIDTH'($urandom);
        data[TAPCNT_WIDTH-1:0] = taps_m1;
        write_register(CFG_TAP_COUNT, data);
        data = CFG_DATA_WIDTH'($urandom);
        data[DECIM_WIDTH-1:0] = decim;
        write_register(CFG_DECIMATION, data);
        write_register(CFG_PACKET_LENGTH, pkt_len);
        settings_used++;
    endtask

    function automatic logic signed [IN_WIDTH-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return {1'b0, {(IN_WIDTH - 1){1'b1}}};
            1:       return {1'b1, {(IN_WIDTH - 1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return IN_WIDTH'($urandom);
        endcase
    endfunction

    function automatic fir_req_t build_request(input logic                       op,
                                               input logic [IDX_WIDTH-1:0]       idx,
                                               input logic signed [IN_WIDTH-1:0] val,
                                               input logic signed [IN_WIDTH-1:0] l,
                                               input logic signed [IN_WIDTH-1:0] r);
        fir_req_t req;
        req.op    = op;
        req.cidx  = idx;
        req.cval  = val;
        req.left  = l;
        req.right = r;
        return req;
    endfunction

    function automatic fir_req_t random_request(input logic [TAPCNT_WIDTH-1:0] taps_m1);
        fir_req_t req;
        req.op    = ($urandom_range(99) < 20) ? OP_COEFF : OP_SAMPLE;
        req.cidx  = ($urandom_range(99) < 70) ? IDX_WIDTH'($urandom_range(taps_m1))
                                              : IDX_WIDTH'($urandom);
        req.cval  = pick_sample();
        req.left  = pick_sample();
        req.right = pick_sample();
        return req;
    endfunction

    // reset registers: 128 taps, every pair, 256-word packets
    task automatic test_reset_defaults();
        send_request(build_request(OP_SAMPLE, 9'd3, 16'sh1234, 16'sh7FFF, -16'sh8000));
        send_request(build_request(OP_COEFF, 9'd0, 16'sh7FFF, 16'sh0, 16'sh0));
        send_request(build_request(OP_COEFF, 9'd1, -16'sh8000, 16'sh0, 16'sh0));
        send_request(build_request(OP_COEFF, 9'd127, -16'sh1, 16'sh0, 16'sh0));
        send_request(build_request(OP_COEFF, 9'd128, 16'sh1, 16'sh0, 16'sh0));
        send_request(build_request(OP_COEFF, 9'd511, 16'sh5A5A, -16'sh1, -16'sh1));
        send_request(build_request(OP_SAMPLE, 9'd0, 16'sh0, -16'sh8000, -16'sh8000));
        send_request(build_request(OP_SAMPLE, 9'd0, 16'sh0, 16'sh7FFF, -16'sh8000));
        send_request(build_request(OP_SAMPLE, 9'd0, 16'sh0, -16'sh1, 16'sh1));
        send_request(build_request(OP_SAMPLE, 9'd0, 16'sh0, 16'sh5555, -16'sh5556));
        send_request(build_request(OP_SAMPLE, 9'd511, -16'sh1, 16'sh0, 16'sh7FFF));
        settings_used++;
    endtask

    // full and single tap spans, deepest and zero decimation, one-word, longest
    // and wrap-only packets, writes to the unused register index
    task automatic test_register_extremes();
        settle_idle();
        write_register(CFG_TAP_COUNT, '1);
        write_register(CFG_DECIMATION, '1);
        write_register(CFG_PACKET_LENGTH, 16'd1);
        settings_used++;
        repeat (8)
            send_request(build_request(OP_SAMPLE, '0, '0, pick_sample(), pick_sample()));
        settle_idle();
        write_register(CFG_UNUSED, '1);
        write_register(CFG_UNUSED, '0);
        write_register(CFG_TAP_COUNT, '0);
        write_register(CFG_DECIMATION, '0);
        write_register(CFG_PACKET_LENGTH, 16'hFFFF);
        settings_used++;
        repeat (4)
            send_request(build_request(OP_SAMPLE, '0, '0, pick_sample(), pick_sample()));
        settle_idle();
        write_register(CFG_PACKET_LENGTH, 16'd0);
        settings_used++;
        repeat (2)
            send_request(build_request(OP_SAMPLE, '0, '0, pick_sample(), pick_sample()));
    endtask

    task automatic test_random_stream(input int send_pct, input int recv_pct, input int n_reqs);
        int                      sent;
        int                      phase_len;
        int                      pause_at;
        int                      pick;
        logic [TAPCNT_WIDTH-1:0] taps_m1;
        logic [PKTLEN_WIDTH-1:0] pkt_len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_reqs) begin
            pick = $urandom_range(99);
            if (pick < 70)
                taps_m1 = TAPCNT_WIDTH'($urandom_range(15));
            else if (pick < 92)
                taps_m1 = TAPCNT_WIDTH'($urandom_range(127, 16));
            else if (pick < 96)
                taps_m1 = '1;
            else
                taps_m1 = TAPCNT_WIDTH'($urandom_range(510, 128));
            pick = $urandom_range(99);
            if (pick < 60)
                pkt_len = PKTLEN_WIDTH'($urandom_range(8, 1));
            else if (pick < 80)
                pkt_len = PKTLEN_WIDTH'($urandom_range(300, 9));
            else if (pick < 90)
                pkt_len = pick[0] ? 16'd0 : 16'hFFFF;
            else
                pkt_len = PKTLEN_WIDTH'($urandom);
            configure(taps_m1, DECIM_WIDTH'($urandom), pkt_len);
            phase_len = (taps_m1 > 127) ? $urandom_range(14, 8) : $urandom_range(70, 30);
            pause_at  = $urandom_range(phase_len - 1);
            for (int k = 0; k < phase_len; k++) begin
                // hold off new requests until the pipeline has emptied
                if (k == pause_at)
                    wait_results_done();
                send_request(random_request(taps_m1));
            end
            sent += phase_len;
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 21;
        recv_idle_pct = 58;
        test_reset_defaults();
        test_register_extremes();
        test_random_stream(21, 58, 270);
        test_random_stream(58, 21, 270);
        test_random_stream(0, 0, 260);
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d requests (%0d coefficient loads) over %0d register settings",
                 requests_sent, coeff_writes, settings_used);
        $display("Checked %0d filter words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
